/* rtl/rth_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rth_pkg;
    // Number of fraction bits in hue and saturation.
    localparam int FRAC_BITS = 16;
    // Quotient bits: one integer bit so a full-scale quotient can saturate.
    localparam int QBITS = FRAC_BITS + 1;

    // Hue offset in sixths of a turn.
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_M6   = 2'd1,
        K_M2   = 2'd2,
        K_P4   = 2'd3
    } hue_off_t;

    // Per-stage control that travels alongside the divider data.
    typedef struct packed {
        logic valid;
        logic hue_zero;
        logic sat_zero;
    } rth_flags_t;
endpackage
`default_nettype wire

/* rtl/rth_div_cell.sv */
// One restoring-division cell: produces one quotient bit per word per stage.
// Depends on rth_pkg for the quotient width.
`timescale 1ns / 1ps
`default_nettype none
module rth_div_cell import rth_pkg::*; #(
    parameter int DW = 19
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [DW-1:0]    den_i,
    input  wire logic [DW:0]      rem_i,
    input  wire logic [QBITS-1:0] q_i,
    output logic      [DW-1:0]    den_o,
    output logic      [DW:0]      rem_o,
    output logic      [QBITS-1:0] q_o
);
    logic          ge;
    logic [DW:0]   rsel;

    // Subtract the divisor when it fits, then shift the remainder up.
    assign ge   = rem_i >= {1'b0, den_i};
    assign rsel = ge ? (rem_i - {1'b0, den_i}) : rem_i;

    // Payload registers advance with the pipeline enable.
    always_ff @(posedge aclk) begin
        if (en) begin
            den_o <= den_i;
            rem_o <= {rsel[DW-1:0], 1'b0};
            q_o   <= {q_i[QBITS-2:0], ge};
        end
    end
endmodule
`default_nettype wire

/* rtl/rth_sort.sv */
// Input stage: orders the components, finds chroma and the hue numerator.
// Depends on rth_pkg for the hue offset and flag types.
`timescale 1ns / 1ps
`default_nettype none
module rth_sort import rth_pkg::*; #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         s_valid,
    input  wire logic [W-1:0] s_red,
    input  wire logic [W-1:0] s_green,
    input  wire logic [W-1:0] s_blue,
    output logic      [W+2:0] hnum_o,
    output logic      [W+2:0] hden_o,
    output logic      [W-1:0] chroma_o,
    output logic      [W-1:0] max_o,
    output rth_flags_t        flags_o
);
    localparam int SW = W + 5;

    logic [W-1:0]  g1, b1, r2, g2, lo, c;
    hue_off_t      k1, k2;
    logic [SW-1:0] c_ext, c6, kc, gb, num, anum;

    // Two strict compare-and-swap steps track the hue offset.
    always_comb begin
        g1 = s_green;
        b1 = s_blue;
        k1 = K_ZERO;
        if (s_green < s_blue) begin
            g1 = s_blue;
            b1 = s_green;
            k1 = K_M6;
        end
        r2 = s_red;
        g2 = g1;
        k2 = k1;
        lo = b1;
        if (s_red < g1) begin
            r2 = g1;
            g2 = s_red;
            k2 = (k1 == K_M6) ? K_P4 : K_M2;
            lo = (s_red < b1) ? s_red : b1;
        end
        c = r2 - lo;
    end

    // Hue numerator |k6*c + (g - b)| in signed arithmetic.
    always_comb begin
        c_ext = {{(SW-W){1'b0}}, c};
        c6    = (c_ext << 2) + (c_ext << 1);
        gb    = {{(SW-W){1'b0}}, g2} - {{(SW-W){1'b0}}, b1};
        case (k2)
            K_ZERO:  kc = '0;
            K_M6:    kc = '0 - c6;
            K_M2:    kc = '0 - (c_ext << 1);
            K_P4:    kc = c_ext << 2;
            default: kc = '0;
        endcase
        num  = kc + gb;
        anum = num[SW-1] ? ('0 - num) : num;
    end

    // Stage registers; reset clears only the valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_o.valid <= 1'b0;
        end else if (en) begin
            hnum_o           <= anum[W+2:0];
            hden_o           <= c6[W+2:0];
            chroma_o         <= c;
            max_o            <= r2;
            flags_o.valid    <= s_valid;
            flags_o.hue_zero <= (c == '0);
            flags_o.sat_zero <= (r2 == '0);
        end
    end
endmodule
`default_nettype wire

/* rtl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter: sort stage and two divider chains.
// Depends on rth_pkg, rth_sort and rth_div_cell.
//
// Usage: pixels enter on the s_ channel (s_red, s_green, s_blue) and leave
// on the m_ channel (m_hue, m_saturation, m_brightness), both valid/ready.
// One word is accepted every clock cycle while the output side takes words.
// From acceptance to m_valid a word passes one sort stage, then one
// cell per quotient bit (17 cells) in each of the hue and saturation chains,
// with the last cell acting as the output register.
// Throughput is one pixel per cycle while the output side takes words.
// The whole pipeline advances together: when m_valid is high and m_ready is
// low, every stage holds and s_ready falls, so no word is lost.
// s_ready follows the output register alone, so it is high whenever the
// output register is empty or being read; bubbles in inner stages stay.
// Reset clears all valid bits; the first word can be accepted right after.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter import rth_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [COMPONENT_BITS-1:0] s_red,
    input  wire logic [COMPONENT_BITS-1:0] s_green,
    input  wire logic [COMPONENT_BITS-1:0] s_blue,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [FRAC_BITS-1:0]      m_hue,
    output logic      [FRAC_BITS-1:0]      m_saturation,
    output logic      [COMPONENT_BITS-1:0] m_brightness
);
    localparam int W  = COMPONENT_BITS;
    localparam int HW = W + 3;

    logic en;

    logic [HW-1:0]    hden [0:QBITS];
    logic [HW:0]      hrem [0:QBITS];
    logic [QBITS-1:0] hq   [0:QBITS];
    logic [W-1:0]     sden [0:QBITS];
    logic [W:0]       srem [0:QBITS];
    logic [QBITS-1:0] sq   [0:QBITS];
    rth_flags_t       flg0;
    rth_flags_t       flg_reg [1:QBITS];
    logic [HW-1:0]    hnum0;
    logic [W-1:0]     chroma0;

    // Pipeline enable: move when the output register is empty or taken.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Sort stage.
    rth_sort #(.W(W)) u_sort (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s_valid  (s_valid),
        .s_red    (s_red),
        .s_green  (s_green),
        .s_blue   (s_blue),
        .hnum_o   (hnum0),
        .hden_o   (hden[0]),
        .chroma_o (chroma0),
        .max_o    (sden[0]),
        .flags_o  (flg0)
    );

    assign hrem[0] = {1'b0, hnum0};
    assign hq[0]   = '0;
    assign srem[0] = {1'b0, chroma0};
    assign sq[0]   = '0;

    // Chains of division cells, one quotient bit per stage.
    for (genvar i = 0; i < QBITS; i++) begin : g_chain
        rth_flags_t flg_prev;

        rth_div_cell #(.DW(HW)) u_hcell (
            .aclk  (aclk),
            .en    (en),
            .den_i (hden[i]),
            .rem_i (hrem[i]),
            .q_i   (hq[i]),
            .den_o (hden[i+1]),
            .rem_o (hrem[i+1]),
            .q_o   (hq[i+1])
        );
        rth_div_cell #(.DW(W)) u_scell (
            .aclk  (aclk),
            .en    (en),
            .den_i (sden[i]),
            .rem_i (srem[i]),
            .q_i   (sq[i]),
            .den_o (sden[i+1]),
            .rem_o (srem[i+1]),
            .q_o   (sq[i+1])
        );

        // Flags come from the sort stage or from the previous cell.
        if (i == 0) begin : g_src
            assign flg_prev = flg0;
        end else begin : g_src
            assign flg_prev = flg_reg[i];
        end

        // Side line for flags; the maximum travels as the divisor.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                flg_reg[i+1].valid <= 1'b0;
            end else if (en) begin
                flg_reg[i+1] <= flg_prev;
            end
        end
    end

    // Saturate full-scale quotients and apply the zero rules.
    assign m_valid      = flg_reg[QBITS].valid;
    assign m_brightness = sden[QBITS];
    assign m_hue        = flg_reg[QBITS].hue_zero ? '0 :
                          (hq[QBITS][QBITS-1] ? '1 : hq[QBITS][FRAC_BITS-1:0]);
    assign m_saturation = flg_reg[QBITS].sat_zero ? '0 :
                          (sq[QBITS][QBITS-1] ? '1 : sq[QBITS][FRAC_BITS-1:0]);

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Nonzero saturation needs a nonzero maximum.
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_saturation != '0) |-> (m_brightness != '0))
        else $error("saturation without brightness");

    // Zero brightness means all components are zero, so hue is zero too.
    a_black_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_brightness == '0) |-> (m_hue == '0))
        else $error("hue on black pixel");
endmodule
`default_nettype wire
